// ----- src/fse_pkg.sv -----
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types, constants and sine-table helpers for the Fourier series engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fse_pkg;

    localparam int MAX_TERMS        = 64;
    localparam int MAX_SUBINTERVALS = 4096;
    localparam int TABLE_BITS       = 8;
    localparam int QTAB             = 1 << TABLE_BITS;

    localparam int IDX_W  = $clog2(MAX_TERMS);
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int SUB_W  = 13;
    localparam int PH_W   = 16;
    localparam int STEP_W = 17;
    localparam int WT_W   = 17;
    localparam int Q_W    = 32;
    localparam int TRIG_W = 16;
    localparam int T_W    = 35;
    localparam int PROD_W = T_W + TRIG_W;
    localparam int FW_W   = Q_W + WT_W + 2;
    localparam int CA_W   = 36;
    localparam int ACC_W  = 58;

    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 104;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Cycles between the last issued term and the final result step.
    localparam int DRAIN_CYC = 3;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] QTAB_X2 = 64'(2 * QTAB);

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;
    localparam logic [1:0] CMD_SAMPLE = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
    localparam logic [1:0] ST_BAD_SAMPLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TERMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUB     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT      = 3'd4;

    typedef logic signed [TRIG_W-1:0] t_qwave [0:QTAB];

    typedef struct packed {
        logic             accept;
        logic             mem_op;
        logic             issue;
        logic [IDX_W-1:0] addr;
        logic             load_out;
    } t_dp_ctl;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CNT_W-1:0] n_terms;
        logic             run_zero;
        logic             out_free;
    } t_dp_stat;

    // Quarter sine wave in Q1.15 from a Taylor series, evaluated at elaboration.
    // Each term divides by (2n)(2n+1) for n = 1 to 8.
    function automatic t_qwave build_qwave();
        t_qwave             tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int k = 0; k <= QTAB; k++) begin
            x    = (64'(k) * PI_Q30 + 64'(QTAB)) / QTAB_X2;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd16384) >>> 15;
            if (r > 64'sd32767) begin
                r = 64'sd32767;
            end
            tab[k] = TRIG_W'(r);
        end
        return tab;
    endfunction

    localparam t_qwave QWAVE = build_qwave();

    function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [PH_W-1:0] ph);
        logic [1:0]                q;
        logic [TABLE_BITS-1:0]     k;
        logic [TABLE_BITS:0]       a;
        logic signed [TRIG_W-1:0]  v;
        q = ph[PH_W-1 -: 2];
        k = ph[PH_W-3 -: TABLE_BITS];
        a = q[0] ? ((TABLE_BITS+1)'(QTAB) - {1'b0, k}) : {1'b0, k};
        v = QWAVE[a];
        return q[1] ? -v : v;
    endfunction

    // Clip to 32 bits; bit 32 of the result flags a clip.
    function automatic logic [Q_W:0] sat_q(input logic signed [47:0] v);
        logic [Q_W:0] res;
        if (v > 48'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -48'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[Q_W-1:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/fourier_series_engine_top.sv -----
// ----------------------------------------------------------------------------
// fourier_series_engine_top
// Truncated Fourier series engine: coefficient store, series evaluation and
// trapezoid-rule analysis over a shared sine table and multiplier pair.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per transaction. s_axis_tuser holds the
// command code (write pair, read pair, evaluate, analysis sample) and
// s_axis_tdata the operands. Every command returns exactly one transaction on
// the master stream with the series value, the read-back pair, a status code
// and a saturation flag.
// Evaluation and analysis walk the n coefficients in use (at most 64): the
// walk issues one term a cycle into a pipeline of memory read and table lookup,
// multiply, then accumulate (evaluation) or round and write back (analysis).
// One command is in flight at a time; the next one is accepted as soon as the
// previous result sits in the output register.
// A stalled master side holds the output register and the result of the next
// command waits in the datapath until the register frees up.
// Reset clears the coefficient valid bits, so every pair reads as zero, and
// loads the configuration defaults. The configuration channel is always ready
// and must only be written while no command is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module fourier_series_engine_top
    import fse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [5:0] coef_index, [37:6] cos_value, [69:38] sin_value, [85:70] eval_phase,
    // [117:86] sample_value, [130:118] sample_index, [135:131] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [31:0] series_value, [63:32] read_cos, [95:64] read_sin, [97:96] status,
    // [98] saturated, [103:99] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    fse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    fse_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- src/fse_ctrl.sv -----
// ----------------------------------------------------------------------------
// fse_ctrl
// Sequencer: accepts one command, runs its memory access or coefficient walk,
// drains the datapath pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_ctrl
    import fse_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_ctl       o_ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_MEMOP = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_in_ready   = 1'b0;
        o_ctl        = '0;
        o_ctl.addr   = r_cnt[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                n_cnt = '0;
                if (i_stat.cmd == CMD_WRITE || i_stat.cmd == CMD_READ) begin
                    n_state = S_MEMOP;
                end else if (i_stat.run_zero) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_MEMOP: begin
                o_ctl.mem_op = 1'b1;
                n_state      = S_FIN;
            end
            S_RUN: begin
                o_ctl.issue = 1'b1;
                if (r_cnt + 1'b1 == i_stat.n_terms) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_cnt == CNT_W'(DRAIN_CYC - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- src/fse_datapath.sv -----
// ----------------------------------------------------------------------------
// fse_datapath
// Configuration registers, coefficient memories, sine table lookups, the
// multiply/accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_datapath
    import fse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_ctl               i_ctl,
    output t_dp_stat                   o_stat,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic [IN_USER_W-1:0]  i_in_user,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0]      o_out_data
);

    // Configuration.
    logic [CNT_W-1:0]  r_num_terms;
    logic [SUB_W-1:0]  r_num_sub;
    logic [PH_W-1:0]   r_start;
    logic [STEP_W-1:0] r_step;
    logic [WT_W-1:0]   r_weight;

    // Latched command.
    logic [1:0]            r_cmd;
    logic [IDX_W-1:0]      r_idx;
    logic signed [Q_W-1:0] r_cos_in, r_sin_in, r_f;
    logic [PH_W-1:0]       r_xph;
    logic [SUB_W-1:0]      r_j;

    // Setup products.
    logic signed [FW_W-1:0] r_fw;
    logic [PH_W-1:0]        r_jstep;
    logic signed [T_W-1:0]  r_t;
    logic [PH_W-1:0]        r_phj;
    logic [PH_W-1:0]        r_ph;

    // Coefficient storage.
    logic [Q_W-1:0]       mem_cos [0:MAX_TERMS-1];
    logic [Q_W-1:0]       mem_sin [0:MAX_TERMS-1];
    logic [MAX_TERMS-1:0] r_valid;

    // Pipeline.
    logic                     r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]         r_i1, r_i2, r_i3;
    logic                     r_vb1;
    logic signed [Q_W-1:0]    r_mc, r_ms;
    logic signed [TRIG_W-1:0] r_tc, r_ts;
    logic signed [PROD_W-1:0] r_pc, r_ps;
    logic signed [Q_W-1:0]    r_oc2, r_os2, r_oc3, r_os3;
    logic signed [CA_W-1:0]   r_ca, r_cb;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_clip;

    // Output register.
    logic                  r_out_valid;
    logic [Q_W-1:0]        r_series, r_rc, r_rs;
    logic [1:0]            r_status;
    logic                  r_sat;

    // Decode.
    logic [CNT_W-1:0]      n_terms;
    logic                  bad_idx, bad_j, is_eval, is_sample;
    logic [WT_W:0]         wt;
    logic [29:0]           jprod;
    logic [IDX_W-1:0]      raddr;
    logic [PH_W-1:0]       ph_now;
    logic signed [Q_W-1:0] cm, sm;
    logic signed [T_W-1:0] a_c, a_s;
    logic signed [PROD_W-1:0] pc, ps;
    logic signed [36:0]    sum_c, sum_s;
    logic [Q_W:0]          sat_c, sat_s, sat_e;
    logic signed [ACC_W-1:0] acc_rnd;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [Q_W-1:0]        wdata_c, wdata_s;

    assign n_terms   = (r_num_terms > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : r_num_terms;
    assign bad_idx   = {1'b0, r_idx} >= n_terms;
    assign bad_j     = r_j > r_num_sub;
    assign is_eval   = r_cmd == CMD_EVAL;
    assign is_sample = r_cmd == CMD_SAMPLE;
    assign wt        = (r_j == '0 || r_j == r_num_sub) ? {1'b0, r_weight} : {r_weight, 1'b0};
    assign jprod     = r_j * r_step;

    assign o_stat.cmd      = r_cmd;
    assign o_stat.n_terms  = n_terms;
    assign o_stat.run_zero = (n_terms == '0) || (is_sample && bad_j);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign raddr  = i_ctl.issue ? i_ctl.addr : r_idx;
    assign ph_now = r_ph;

    assign cm  = r_vb1 ? r_mc : '0;
    assign sm  = r_vb1 ? r_ms : '0;
    assign a_c = is_eval ? T_W'(cm) : r_t;
    assign a_s = is_eval ? T_W'(sm) : r_t;
    assign pc  = a_c * r_tc;
    assign ps  = a_s * r_ts;

    assign sum_c = 37'(r_oc3) + 37'(r_ca);
    assign sum_s = 37'(r_os3) + 37'(r_cb);
    assign sat_c = sat_q(48'(sum_c));
    assign sat_s = sat_q(48'(sum_s));
    assign acc_rnd = (r_acc + ACC_W'(16384)) >>> 15;
    // The rounded sum always fits 48 signed bits, so the low bits keep its sign.
    assign sat_e   = sat_q(acc_rnd[47:0]);

    // The analysis write-back owns the port while the pipeline runs.
    assign we      = r_v3 || (i_ctl.mem_op && r_cmd == CMD_WRITE && !bad_idx);
    assign waddr   = r_v3 ? r_i3 : r_idx;
    assign wdata_c = r_v3 ? sat_c[Q_W-1:0] : r_cos_in;
    assign wdata_s = r_v3 ? sat_s[Q_W-1:0] : r_sin_in;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_cos[waddr] <= wdata_c;
            mem_sin[waddr] <= wdata_s;
        end
        r_mc <= mem_cos[raddr];
        r_ms <= mem_sin[raddr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= CNT_W'(64);
            r_num_sub   <= SUB_W'(1);
            r_start     <= '0;
            r_step      <= STEP_W'(65536);
            r_weight    <= WT_W'(65536);
            r_valid     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_TERMS:   r_num_terms <= i_cfg_data[CNT_W-1:0];
                    CFG_NUM_SUB:     r_num_sub   <= i_cfg_data[SUB_W-1:0];
                    CFG_START_PHASE: r_start     <= i_cfg_data[PH_W-1:0];
                    CFG_PHASE_STEP:  r_step      <= i_cfg_data[STEP_W-1:0];
                    CFG_WEIGHT:      r_weight    <= i_cfg_data[WT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && is_sample;
            if (i_ctl.accept) begin
                r_clip <= 1'b0;
            end else if (r_v3 && (sat_c[Q_W] || sat_s[Q_W])) begin
                r_clip <= 1'b1;
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd    <= i_in_user;
            r_idx    <= i_in_data[5:0];
            r_cos_in <= i_in_data[37:6];
            r_sin_in <= i_in_data[69:38];
            r_xph    <= i_in_data[85:70];
            r_f      <= i_in_data[117:86];
            r_j      <= i_in_data[130:118];
            r_ph     <= '0;
            r_acc    <= '0;
        end else begin
            if (i_ctl.issue) begin
                r_ph <= r_ph + (is_eval ? r_xph : r_phj);
            end
            if (r_v2 && is_eval) begin
                r_acc <= r_acc + ACC_W'(r_pc) + ACC_W'(r_ps);
            end
        end

        r_fw    <= r_f * $signed({2'b00, wt});
        r_jstep <= jprod[PH_W-1:0];
        r_t     <= T_W'((r_fw + FW_W'(32768)) >>> 16);
        r_phj   <= r_start + r_jstep;

        // Stage 1: table lookups beside the memory read.
        r_i1  <= i_ctl.addr;
        r_vb1 <= r_valid[raddr];
        if (is_eval && i_ctl.addr == '0) begin
            r_tc <= TRIG_W'(16384);
            r_ts <= '0;
        end else begin
            r_tc <= sin_lookup(ph_now + PH_W'(16384));
            r_ts <= sin_lookup(ph_now);
        end

        // Stage 2: products.
        r_pc  <= pc;
        r_ps  <= ps;
        r_i2  <= r_i1;
        r_oc2 <= (r_j == '0) ? '0 : cm;
        r_os2 <= (r_j == '0) ? '0 : sm;

        // Stage 3: rounded contributions.
        r_ca  <= CA_W'((r_pc + PROD_W'(16384)) >>> 15);
        r_cb  <= CA_W'((r_ps + PROD_W'(16384)) >>> 15);
        r_i3  <= r_i2;
        r_oc3 <= r_oc2;
        r_os3 <= r_os2;

        if (i_ctl.load_out) begin
            r_series <= is_eval ? sat_e[Q_W-1:0] : '0;
            r_rc     <= (r_cmd == CMD_READ && !bad_idx && r_vb1) ? r_mc : '0;
            r_rs     <= (r_cmd == CMD_READ && !bad_idx && r_vb1) ? r_ms : '0;
            if ((r_cmd == CMD_WRITE || r_cmd == CMD_READ) && bad_idx) begin
                r_status <= ST_BAD_INDEX;
            end else if (is_sample && bad_j) begin
                r_status <= ST_BAD_SAMPLE;
            end else begin
                r_status <= ST_OK;
            end
            r_sat <= is_eval ? (sat_e[Q_W] && n_terms != '0) : (is_sample && r_clip);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {5'b0, r_sat, r_status, r_rs, r_rc, r_series};

endmodule

`default_nettype wire

// ----- src/fse_checker.sv -----
// ----------------------------------------------------------------------------
// fse_checker
// Port-level checks for the Fourier series engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_checker
    import fse_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // One command at a time: an accepted transaction closes the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after accepting a command");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[97:96] != ST_BAD_INDEX + ST_BAD_SAMPLE)
        else $error("undefined status code");

    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[97:96] == ST_BAD_INDEX |->
        m_axis_tdata[95:0] == '0 && !m_axis_tdata[98])
        else $error("index error carries data");

endmodule

bind fourier_series_engine_top fse_checker u_fse_checker (.*);

`default_nettype wire
